>>> sv/psad_pkg.sv
// psad_pkg: shared constants, types and tables for the patch SAD / energy block.
// Used by psad_front, psad_fifo, psad_back and patch_sad_energy. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package psad_pkg;

    // Field widths
    localparam int PIX_W       = 8;
    localparam int COORD_W     = 14;
    localparam int SIZE_W      = 13;
    localparam int RAD_W       = 3;
    localparam int MODE_W      = 2;
    localparam int PAIR_COST_W = 12;
    localparam int COST_W      = 20;
    localparam int EN_W        = 31;
    localparam int KXA_W       = 17;

    // Stream and config port widths
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 56;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 13;

    // Queue between front and back
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = 2;

    // Limits
    localparam logic [SIZE_W-1:0] SIZE_LIM = 13'd4096;
    localparam logic [COST_W-1:0] COST_MAX = 20'hFFFFF;
    localparam logic [EN_W-1:0]   EN_MAX   = 31'h3FFF_FFFF;
    localparam logic [EN_W-1:0]   EN_MIN   = 31'h4000_0000;

    // Mode codes (code 3 behaves as plain)
    localparam logic [MODE_W-1:0] MODE_PLAIN    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WEIGHTED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LUMA     = 2'd2;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_MODE   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RADIUS = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SRC_H  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SRC_W  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_DST_H  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_DST_W  = 3'd5;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [RAD_W-1:0]  radius;
        logic [SIZE_W-1:0] src_h;
        logic [SIZE_W-1:0] src_w;
        logic [SIZE_W-1:0] dst_h;
        logic [SIZE_W-1:0] dst_w;
    } t_cfg;

    // One classified pixel pair, front to back
    typedef struct packed {
        logic [PAIR_COST_W-1:0] cost;
        logic                   bad;
        logic                   last;
        logic                   send;
    } t_pair;

    // 100 * (2r+1)^2, the lowest mode constant times patch area
    function automatic logic [KXA_W-1:0] area100(input logic [RAD_W-1:0] r);
        logic [KXA_W-1:0] a;
        case (r)
            3'd0:    a = 17'd100;
            3'd1:    a = 17'd900;
            3'd2:    a = 17'd2500;
            3'd3:    a = 17'd4900;
            3'd4:    a = 17'd8100;
            3'd5:    a = 17'd12100;
            3'd6:    a = 17'd16900;
            default: a = 17'd22500;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

>>> sv/psad_front.sv
// psad_front: per-pair cost in quarter units and centre border check.
// Depends on psad_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psad_front (
    input  wire psad_pkg::t_cfg                       i_cfg,
    input  wire logic [psad_pkg::PIX_W-1:0]           i_src_c0,
    input  wire logic [psad_pkg::PIX_W-1:0]           i_src_c1,
    input  wire logic [psad_pkg::PIX_W-1:0]           i_src_c2,
    input  wire logic [psad_pkg::PIX_W-1:0]           i_dst_c0,
    input  wire logic [psad_pkg::PIX_W-1:0]           i_dst_c1,
    input  wire logic [psad_pkg::PIX_W-1:0]           i_dst_c2,
    input  wire logic signed [psad_pkg::COORD_W-1:0]  i_src_row,
    input  wire logic signed [psad_pkg::COORD_W-1:0]  i_src_col,
    input  wire logic signed [psad_pkg::COORD_W-1:0]  i_dst_row,
    input  wire logic signed [psad_pkg::COORD_W-1:0]  i_dst_col,
    input  wire logic                                 i_patch_end,
    input  wire logic                                 i_set_end,
    output psad_pkg::t_pair                           o_pair
);

    function automatic logic [psad_pkg::PIX_W-1:0] absd(
        input logic [psad_pkg::PIX_W-1:0] a,
        input logic [psad_pkg::PIX_W-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // Centre lies outside [r, size-r), size clamped to SIZE_LIM (4096)
    function automatic logic outside(
        input logic signed [psad_pkg::COORD_W-1:0] c,
        input logic [psad_pkg::SIZE_W-1:0]         size,
        input logic [psad_pkg::RAD_W-1:0]          r
    );
        logic [psad_pkg::SIZE_W-1:0] sz;
        logic signed [psad_pkg::COORD_W:0] cc;
        logic signed [psad_pkg::COORD_W:0] lo;
        logic signed [psad_pkg::COORD_W:0] hi;
        sz = (size > psad_pkg::SIZE_LIM) ? psad_pkg::SIZE_LIM : size;
        cc = {c[psad_pkg::COORD_W-1], c};
        lo = $signed({{(psad_pkg::COORD_W+1-psad_pkg::RAD_W){1'b0}}, r});
        hi = $signed({{(psad_pkg::COORD_W+1-psad_pkg::SIZE_W){1'b0}}, sz}) - lo;
        return (cc < lo) || (cc >= hi);
    endfunction

    logic [psad_pkg::PIX_W-1:0]       w_d0, w_d1, w_d2;
    logic [psad_pkg::PIX_W+2:0]       w_ys_sum, w_yd_sum;
    logic [psad_pkg::PIX_W-1:0]       w_dy;
    logic [psad_pkg::PIX_W+1:0]       w_rgb_sum;
    logic [psad_pkg::PAIR_COST_W-1:0] w_cost;

    assign w_d0 = absd(i_src_c0, i_dst_c0);
    assign w_d1 = absd(i_src_c1, i_dst_c1);
    assign w_d2 = absd(i_src_c2, i_dst_c2);

    // Luminance c0 + 4*c1 + 3*c2, then divide by 8
    assign w_ys_sum = 11'(i_src_c0) + {1'b0, i_src_c1, 2'b00}
                    + 11'({i_src_c2, 1'b0}) + 11'(i_src_c2);
    assign w_yd_sum = 11'(i_dst_c0) + {1'b0, i_dst_c1, 2'b00}
                    + 11'({i_dst_c2, 1'b0}) + 11'(i_dst_c2);
    assign w_dy     = absd(w_ys_sum[10:3], w_yd_sum[10:3]);

    assign w_rgb_sum = 10'(w_d0) + 10'(w_d1) + 10'(w_d2);

    // Pair cost by mode
    always_comb begin
        unique case (i_cfg.mode)
            psad_pkg::MODE_WEIGHTED: begin
                w_cost = 12'({w_d0, 1'b0}) + 12'(w_d1) + 12'(w_d2);
            end
            psad_pkg::MODE_LUMA: begin
                w_cost = 12'({w_dy, 2'b00});
            end
            default: begin
                w_cost = {w_rgb_sum, 2'b00};
            end
        endcase
    end

    assign o_pair.cost = w_cost;
    assign o_pair.bad  = outside(i_src_row, i_cfg.src_h, i_cfg.radius)
                       | outside(i_src_col, i_cfg.src_w, i_cfg.radius)
                       | outside(i_dst_row, i_cfg.dst_h, i_cfg.radius)
                       | outside(i_dst_col, i_cfg.dst_w, i_cfg.radius);
    assign o_pair.last = i_patch_end | i_set_end;
    assign o_pair.send = i_set_end;

endmodule

`default_nettype wire

>>> sv/psad_fifo.sv
// psad_fifo: short queue of classified pairs between front and back.
// Depends on psad_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psad_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire psad_pkg::t_pair   i_data,
    input  wire logic              i_pop,
    output psad_pkg::t_pair        o_data,
    output logic                   o_full,
    output logic                   o_empty
);

    psad_pkg::t_pair r_mem [psad_pkg::FIFO_DEPTH];
    logic [psad_pkg::FIFO_PTR_W:0] r_wr, r_rd;

    assign o_empty = (r_wr == r_rd);
    assign o_full  = (r_wr[psad_pkg::FIFO_PTR_W] != r_rd[psad_pkg::FIFO_PTR_W])
                   && (r_wr[psad_pkg::FIFO_PTR_W-1:0] == r_rd[psad_pkg::FIFO_PTR_W-1:0]);
    assign o_data  = r_mem[r_rd[psad_pkg::FIFO_PTR_W-1:0]];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr[psad_pkg::FIFO_PTR_W-1:0]] <= i_data;
        end
    end

    // Pointers, wrap bit on top
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/psad_back.sv
// psad_back: patch accumulation, energy update with saturation, output register.
// Depends on psad_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psad_back (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire psad_pkg::t_cfg                         i_cfg,
    input  wire psad_pkg::t_pair                        i_pair,
    input  wire logic                                   i_pair_valid,
    output logic                                        o_pop,
    output logic                                        o_tvalid,
    input  wire logic                                   i_tready,
    output logic [psad_pkg::OUT_TDATA_W-1:0]            o_tdata,
    output logic                                        o_tlast
);

    // Mode constant times patch area
    logic [psad_pkg::KXA_W-1:0] r_kxa;

    always_ff @(posedge i_clk) begin
        unique case (i_cfg.mode)
            psad_pkg::MODE_WEIGHTED: r_kxa <= psad_pkg::area100(i_cfg.radius) << 1;
            psad_pkg::MODE_LUMA:     r_kxa <= psad_pkg::area100(i_cfg.radius);
            default:                 r_kxa <= psad_pkg::area100(i_cfg.radius) << 2;
        endcase
    end

    logic                          r_out_valid;
    logic                          w_out_free;
    logic                          r_pd_valid;
    logic                          w_pd_free;
    logic [psad_pkg::COST_W-1:0]   r_acc;
    logic                          r_bad;
    logic [psad_pkg::COST_W-1:0]   r_pd_cost;
    logic                          r_pd_bad;
    logic                          r_pd_send;
    logic [psad_pkg::COST_W:0]     w_sum;
    logic [psad_pkg::COST_W-1:0]   w_acc_sat;

    assign w_out_free = !r_out_valid || i_tready;
    assign w_pd_free  = !r_pd_valid || w_out_free;
    assign o_pop      = i_pair_valid && (!i_pair.last || w_pd_free);

    assign w_sum     = {1'b0, r_acc} + 21'(i_pair.cost);
    assign w_acc_sat = w_sum[psad_pkg::COST_W] ? psad_pkg::COST_MAX
                                               : w_sum[psad_pkg::COST_W-1:0];

    // Patch accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_bad      <= 1'b0;
            r_pd_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                if (i_pair.last) begin
                    r_acc <= '0;
                    r_bad <= 1'b0;
                end else begin
                    r_acc <= w_acc_sat;
                    r_bad <= r_bad | i_pair.bad;
                end
            end
            if (o_pop && i_pair.last) begin
                r_pd_valid <= 1'b1;
            end else if (w_out_free) begin
                r_pd_valid <= 1'b0;
            end
        end
    end

    // Finished patch record
    always_ff @(posedge i_clk) begin
        if (o_pop && i_pair.last) begin
            r_pd_cost <= w_acc_sat;
            r_pd_bad  <= r_bad | i_pair.bad;
            r_pd_send <= i_pair.send;
        end
    end

    // Energy update
    logic                               w_load;
    logic signed [psad_pkg::EN_W+1:0]   w_e_sum;
    logic [psad_pkg::EN_W-1:0]          w_e_sat;
    logic [psad_pkg::EN_W-1:0]          w_en_new;
    logic                               w_en_bad_new;
    logic [psad_pkg::EN_W-1:0]          r_en;
    logic                               r_en_bad;
    logic [psad_pkg::COST_W-1:0]        r_o_cost;
    logic                               r_o_pinf;
    logic [psad_pkg::EN_W-1:0]          r_o_energy;
    logic                               r_o_einf;
    logic                               r_o_last;

    assign w_load  = r_pd_valid && w_out_free;
    assign w_e_sum = $signed({{2{r_en[psad_pkg::EN_W-1]}}, r_en})
                   + $signed({13'b0, r_pd_cost})
                   - $signed({16'b0, r_kxa});

    // Fits when the top three bits agree, else clamp by sign
    always_comb begin
        if (w_e_sum[32:30] == 3'b000 || w_e_sum[32:30] == 3'b111) begin
            w_e_sat = w_e_sum[psad_pkg::EN_W-1:0];
        end else if (w_e_sum[32]) begin
            w_e_sat = psad_pkg::EN_MIN;
        end else begin
            w_e_sat = psad_pkg::EN_MAX;
        end
    end

    assign w_en_new     = r_pd_bad ? r_en : w_e_sat;
    assign w_en_bad_new = r_en_bad | r_pd_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en        <= '0;
            r_en_bad    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_en        <= r_pd_send ? '0 : w_en_new;
                r_en_bad    <= r_pd_send ? 1'b0 : w_en_bad_new;
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_cost   <= r_pd_bad ? psad_pkg::COST_MAX : r_pd_cost;
            r_o_pinf   <= r_pd_bad;
            r_o_energy <= w_en_bad_new ? psad_pkg::EN_MAX : w_en_new;
            r_o_einf   <= w_en_bad_new;
            r_o_last   <= r_pd_send;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = {3'b000, r_o_einf, r_o_energy, r_o_pinf, r_o_cost};
    assign o_tlast  = r_o_last;

endmodule

`default_nettype wire

>>> sv/patch_sad_energy.sv
// patch_sad_energy: streaming patch SAD cost and running energy.
// Depends on psad_pkg, psad_front, psad_fifo and psad_back.
// Throughput: one pixel pair per cycle while the queue has room; the back accumulates one
// pair per cycle, but a patch's last pair waits for a free patch record. A result passes
// the patch record, then the output register; m_axis_tready stalls delay it.
// Reset (i_rst_n low, synchronous): registers to reset values, queue empty, no result.
`timescale 1ns / 1ps
`default_nettype none

module patch_sad_energy (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // tdata: src_c0, src_c1, src_c2, dst_c0, dst_c1, dst_c2 (8 each),
    //        src_row, src_col, dst_row, dst_col (14 each, signed)
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    input  wire logic [psad_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
    input  wire logic                                   s_axis_tlast,   // patch_end
    input  wire logic                                   s_axis_tuser,   // set_end
    // tdata: patch_cost (20), patch_infinite (1), energy (31, signed),
    //        energy_infinite (1), zero fill (3)
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    output logic [psad_pkg::OUT_TDATA_W-1:0]            m_axis_tdata,
    output logic                                        m_axis_tlast,   // set_done
    // Configuration writes
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [psad_pkg::CFG_ADDR_W-1:0]        i_cfg_addr,
    input  wire logic [psad_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    psad_pkg::t_cfg r_cfg;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode   <= psad_pkg::MODE_PLAIN;
            r_cfg.radius <= 3'd1;
            r_cfg.src_h  <= psad_pkg::SIZE_LIM;
            r_cfg.src_w  <= psad_pkg::SIZE_LIM;
            r_cfg.dst_h  <= psad_pkg::SIZE_LIM;
            r_cfg.dst_w  <= psad_pkg::SIZE_LIM;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_addr)
                psad_pkg::CFG_MODE:   r_cfg.mode   <= i_cfg_data[psad_pkg::MODE_W-1:0];
                psad_pkg::CFG_RADIUS: r_cfg.radius <= i_cfg_data[psad_pkg::RAD_W-1:0];
                psad_pkg::CFG_SRC_H:  r_cfg.src_h  <= i_cfg_data;
                psad_pkg::CFG_SRC_W:  r_cfg.src_w  <= i_cfg_data;
                psad_pkg::CFG_DST_H:  r_cfg.dst_h  <= i_cfg_data;
                psad_pkg::CFG_DST_W:  r_cfg.dst_w  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front: classify each pair
    psad_pkg::t_pair w_in_pair;
    psad_pkg::t_pair w_q_pair;
    logic            w_full, w_empty, w_push, w_pop;

    psad_front u_front (
        .i_cfg       (r_cfg),
        .i_src_c0    (s_axis_tdata[7:0]),
        .i_src_c1    (s_axis_tdata[15:8]),
        .i_src_c2    (s_axis_tdata[23:16]),
        .i_dst_c0    (s_axis_tdata[31:24]),
        .i_dst_c1    (s_axis_tdata[39:32]),
        .i_dst_c2    (s_axis_tdata[47:40]),
        .i_src_row   ($signed(s_axis_tdata[61:48])),
        .i_src_col   ($signed(s_axis_tdata[75:62])),
        .i_dst_row   ($signed(s_axis_tdata[89:76])),
        .i_dst_col   ($signed(s_axis_tdata[103:90])),
        .i_patch_end (s_axis_tlast),
        .i_set_end   (s_axis_tuser),
        .o_pair      (w_in_pair)
    );

    assign s_axis_tready = !w_full;
    assign w_push        = s_axis_tvalid && !w_full;

    // Queue between front and back
    psad_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_in_pair),
        .i_pop   (w_pop),
        .o_data  (w_q_pair),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // Back: accumulate, energy, result register
    psad_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_pair       (w_q_pair),
        .i_pair_valid (!w_empty),
        .o_pop        (w_pop),
        .o_tvalid     (m_axis_tvalid),
        .i_tready     (m_axis_tready),
        .o_tdata      (m_axis_tdata),
        .o_tlast      (m_axis_tlast)
    );

    // An infinite patch reports the saturated cost
    a_pinf_cost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[20] |-> m_axis_tdata[19:0] == psad_pkg::COST_MAX)
        else $error("infinite patch without saturated cost");

    // Infinite energy reports the maximum energy
    a_einf_energy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[52] |-> m_axis_tdata[51:21] == psad_pkg::EN_MAX)
        else $error("infinite energy without maximum value");

    // An infinite patch makes the energy infinite
    a_pinf_einf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[20] |-> m_axis_tdata[52])
        else $error("infinite patch left energy finite");

    // The queue never pops while empty
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("queue popped while empty");

endmodule

`default_nettype wire
